// File: rtl/kbd_link_pkg.sv
// ----------------------------------------------------------------------------
// kbd_link_pkg
// Shared types and constants of the keyboard serial link decoder.
// ----------------------------------------------------------------------------
package kbd_link_pkg;

    localparam int unsigned FRAME_TICKS = 48;
    localparam int unsigned PHASE_W     = 16;
    localparam int unsigned DELAY_W     = 15;

    localparam logic [PHASE_W-1:0] FRAME_LAST    = PHASE_W'(FRAME_TICKS - 1);
    localparam logic [DELAY_W-1:0] DELAY_DEFAULT = DELAY_W'(200);

    // slots inside a frame
    localparam logic [PHASE_W-1:0] SLOT_TX_START  = PHASE_W'(0);
    localparam logic [PHASE_W-1:0] SLOT_RX_START  = PHASE_W'(1);
    localparam logic [PHASE_W-1:0] SLOT_TX_DATA_0 = PHASE_W'(2);
    localparam logic [PHASE_W-1:0] SLOT_RX_DATA_0 = PHASE_W'(3);
    localparam logic [PHASE_W-1:0] SLOT_TX_DATA_7 = PHASE_W'(16);
    localparam logic [PHASE_W-1:0] SLOT_RX_DATA_7 = PHASE_W'(17);
    localparam logic [PHASE_W-1:0] SLOT_TX_PARITY = PHASE_W'(18);
    localparam logic [PHASE_W-1:0] SLOT_RX_CHECK  = PHASE_W'(19);
    localparam logic [PHASE_W-1:0] SLOT_TX_STOP   = PHASE_W'(20);

    localparam logic [7:0] BYTE_START      = 8'h2B;
    localparam logic [7:0] BYTE_IDLE       = 8'h4D;
    localparam logic [7:0] BYTE_REPEAT     = 8'hE9;
    localparam logic [7:0] BYTE_STATUS     = 8'hEA;
    localparam logic [7:0] BYTE_MOD_CTRL   = 8'hE0;
    localparam logic [7:0] BYTE_MOD_SHIFT  = 8'hE3;
    localparam logic [7:0] BYTE_MOD_FUNC   = 8'hE5;
    localparam logic [7:0] BYTE_MOD_ALT    = 8'hF8;
    localparam logic [7:0] RX_MSB          = 8'h80;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_READ_RAW = 2'd1,
        OP_READ_KEY = 2'd2,
        OP_READ_MOD = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t opcode;
        logic    line_in;
    } req_t;

    typedef struct packed {
        logic       line_out;
        logic [7:0] raw_byte;
        logic       raw_present;
        logic [7:0] key_code;
        logic [7:0] modifier_code;
    } rsp_t;

endpackage

// File: rtl/kbd_link_if.sv
// ----------------------------------------------------------------------------
// kbd_link_if
// Valid/ready channels of the keyboard serial link decoder.
// ----------------------------------------------------------------------------
interface kbd_req_if;
    logic               valid;
    logic               ready;
    kbd_link_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface kbd_rsp_if;
    logic               valid;
    logic               ready;
    kbd_link_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface kbd_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [kbd_link_pkg::DELAY_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/kbd_link_core.sv
// ----------------------------------------------------------------------------
// kbd_link_core
// Link state: frame phase, transmit and receive shifters, byte decoder and
// the read registers. Computes the result word of each accepted item.
// ----------------------------------------------------------------------------
module kbd_link_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_accept,
    input  kbd_link_pkg::req_t               item,
    input  logic                             cfg_write,
    input  logic [kbd_link_pkg::DELAY_W-1:0] cfg_data,
    output kbd_link_pkg::rsp_t               result
);

    localparam int unsigned PW = kbd_link_pkg::PHASE_W;
    localparam int unsigned DW = kbd_link_pkg::DELAY_W;

    logic [DW-1:0] delay_reg,      delay_next;
    logic [PW-1:0] phase_reg,      phase_next;
    logic [7:0]    tx_shift_reg,   tx_shift_next;
    logic          tx_par_reg,     tx_par_next;
    logic [7:0]    rx_shift_reg,   rx_shift_next;
    logic          rx_start_reg,   rx_start_next;
    logic          rx_par_reg,     rx_par_next;
    logic          expect_reg,     expect_next;
    logic          raw_flag_reg,   raw_flag_next;
    logic [7:0]    raw_store_reg,  raw_store_next;
    logic          key_pend_reg,   key_pend_next;
    logic [7:0]    key_store_reg,  key_store_next;
    logic [7:0]    mod_store_reg,  mod_store_next;
    logic          line_reg,       line_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg     <= kbd_link_pkg::DELAY_DEFAULT;
            phase_reg     <= PW'(0) - {1'b0, kbd_link_pkg::DELAY_DEFAULT};
            tx_shift_reg  <= kbd_link_pkg::BYTE_START;
            tx_par_reg    <= 1'b0;
            rx_shift_reg  <= 8'h00;
            rx_start_reg  <= 1'b1;
            rx_par_reg    <= 1'b0;
            expect_reg    <= 1'b0;
            raw_flag_reg  <= 1'b0;
            raw_store_reg <= 8'h00;
            key_pend_reg  <= 1'b0;
            key_store_reg <= 8'h00;
            mod_store_reg <= 8'h00;
            line_reg      <= 1'b1;
        end
        else
        begin
            delay_reg     <= delay_next;
            phase_reg     <= phase_next;
            tx_shift_reg  <= tx_shift_next;
            tx_par_reg    <= tx_par_next;
            rx_shift_reg  <= rx_shift_next;
            rx_start_reg  <= rx_start_next;
            rx_par_reg    <= rx_par_next;
            expect_reg    <= expect_next;
            raw_flag_reg  <= raw_flag_next;
            raw_store_reg <= raw_store_next;
            key_pend_reg  <= key_pend_next;
            key_store_reg <= key_store_next;
            mod_store_reg <= mod_store_next;
            line_reg      <= line_next;
        end
    end

    always_comb
    begin
        logic keep_byte;
        delay_next     = delay_reg;
        phase_next     = phase_reg;
        tx_shift_next  = tx_shift_reg;
        tx_par_next    = tx_par_reg;
        rx_shift_next  = rx_shift_reg;
        rx_start_next  = rx_start_reg;
        rx_par_next    = rx_par_reg;
        expect_next    = expect_reg;
        raw_flag_next  = raw_flag_reg;
        raw_store_next = raw_store_reg;
        key_pend_next  = key_pend_reg;
        key_store_next = key_store_reg;
        mod_store_next = mod_store_reg;
        line_next      = line_reg;
        keep_byte      = 1'b1;
        result         = '0;

        if (item_accept)
        begin
            unique case (item.opcode)
                kbd_link_pkg::OP_TICK:
                begin
                    phase_next = phase_reg + PW'(1);
                    // negative phase: start-up delay still running
                    if (!phase_reg[PW-1])
                    begin
                        if (phase_reg == kbd_link_pkg::SLOT_TX_START)
                        begin
                            line_next   = 1'b0;
                            tx_par_next = 1'b1;
                        end
                        else if (phase_reg >= kbd_link_pkg::SLOT_TX_DATA_0 &&
                                 phase_reg <= kbd_link_pkg::SLOT_TX_DATA_7 &&
                                 !phase_reg[0])
                        begin
                            line_next     = tx_shift_reg[0];
                            tx_par_next   = tx_par_reg ^ tx_shift_reg[0];
                            tx_shift_next = tx_shift_reg >> 1;
                        end
                        else if (phase_reg == kbd_link_pkg::SLOT_TX_PARITY)
                        begin
                            line_next = tx_par_reg;
                        end
                        else if (phase_reg == kbd_link_pkg::SLOT_TX_STOP)
                        begin
                            line_next = 1'b1;
                        end
                        else if (phase_reg == kbd_link_pkg::SLOT_RX_START)
                        begin
                            rx_start_next = item.line_in;
                            rx_par_next   = 1'b1;
                        end
                        else if (phase_reg >= kbd_link_pkg::SLOT_RX_DATA_0 &&
                                 phase_reg <= kbd_link_pkg::SLOT_RX_DATA_7 &&
                                 phase_reg[0])
                        begin
                            rx_shift_next = (rx_shift_reg >> 1) |
                                            (item.line_in ? kbd_link_pkg::RX_MSB : 8'h00);
                            rx_par_next   = rx_par_reg ^ item.line_in;
                        end
                        else if (phase_reg == kbd_link_pkg::SLOT_RX_CHECK)
                        begin
                            if (!rx_start_reg && item.line_in == rx_par_reg)
                            begin
                                if (expect_reg)
                                begin
                                    expect_next = 1'b0;
                                end
                                else
                                begin
                                    case (rx_shift_reg) inside
                                        kbd_link_pkg::BYTE_IDLE:
                                            keep_byte = 1'b0;
                                        kbd_link_pkg::BYTE_REPEAT:
                                            key_pend_next = 1'b1;
                                        kbd_link_pkg::BYTE_STATUS:
                                            expect_next = 1'b1;
                                        kbd_link_pkg::BYTE_MOD_CTRL,
                                        kbd_link_pkg::BYTE_MOD_SHIFT,
                                        kbd_link_pkg::BYTE_MOD_FUNC,
                                        kbd_link_pkg::BYTE_MOD_ALT:
                                            mod_store_next = rx_shift_reg;
                                        default:
                                        begin
                                            key_store_next = rx_shift_reg;
                                            key_pend_next  = 1'b1;
                                        end
                                    endcase
                                end
                                if (keep_byte)
                                begin
                                    raw_store_next = rx_shift_reg;
                                    raw_flag_next  = 1'b1;
                                end
                            end
                        end
                        else if (phase_reg == kbd_link_pkg::FRAME_LAST)
                        begin
                            phase_next    = '0;
                            tx_shift_next = kbd_link_pkg::BYTE_IDLE;
                        end
                    end
                end
                kbd_link_pkg::OP_READ_RAW:
                begin
                    result.raw_byte    = raw_store_reg;
                    result.raw_present = raw_flag_reg;
                    raw_flag_next      = 1'b0;
                end
                kbd_link_pkg::OP_READ_KEY:
                begin
                    if (key_pend_reg)
                    begin
                        result.key_code = key_store_reg;
                    end
                    key_pend_next = 1'b0;
                end
                kbd_link_pkg::OP_READ_MOD:
                begin
                    result.modifier_code = mod_store_reg;
                end
                default:
                begin
                end
            endcase
        end

        // a new delay restarts the count while still in start-up
        if (cfg_write)
        begin
            delay_next = cfg_data;
            if (phase_reg[PW-1])
            begin
                phase_next = PW'(0) - {1'b0, cfg_data};
            end
        end

        result.line_out = line_next;
    end

    a_raw_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        item_accept && item.opcode == kbd_link_pkg::OP_READ_RAW |=> !raw_flag_reg)
        else $error("raw flag survived a raw read");

    a_key_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        item_accept && item.opcode == kbd_link_pkg::OP_READ_KEY |=> !key_pend_reg)
        else $error("key pending survived a key read");

    a_line_idle_startup: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg[PW-1] |-> line_reg)
        else $error("line driven low during start-up delay");

    a_phase_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        !phase_reg[PW-1] |-> phase_reg <= kbd_link_pkg::FRAME_LAST)
        else $error("phase ran past the end of the frame");

endmodule

// File: rtl/kbd_link_obuf.sv
// ----------------------------------------------------------------------------
// kbd_link_obuf
// Result register with a skid stage, so a word can be taken in while the
// previous one waits at the output.
// ----------------------------------------------------------------------------
module kbd_link_obuf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  kbd_link_pkg::rsp_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output kbd_link_pkg::rsp_t out_data
);

    logic               out_valid_reg,  out_valid_next;
    kbd_link_pkg::rsp_t out_data_reg,   out_data_next;
    logic               skid_valid_reg, skid_valid_next;
    kbd_link_pkg::rsp_t skid_data_reg,  skid_data_next;
    logic               in_take;
    logic               out_take;

    assign in_ready  = !skid_valid_reg;
    assign in_take   = in_valid && in_ready;
    assign out_take  = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_take)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_valid_next = 1'b1;
                out_data_next  = in_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = in_data;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a word with the output empty");

    a_skid_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && out_valid_reg && !out_ready |=> skid_valid_reg)
        else $error("word taken in during stall was not parked");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && out_ready |=> out_valid_reg && !skid_valid_reg)
        else $error("parked word did not move to the output");

endmodule

// File: rtl/keyboard_serial_link_decoder.sv
// ----------------------------------------------------------------------------
// keyboard_serial_link_decoder
// Keyboard link master advanced by tick words; decodes received frames into
// key, modifier and raw bytes and answers read words.
// ----------------------------------------------------------------------------
//  channel  role  word
//  req      sink  opcode, line_in
//  rsp      src   line_out, raw_byte, raw_present, key_code, modifier_code
//  cfg      sink  startup_delay_ticks (always ready)
//
//  one request word per clock while the result buffer has room; its response
//  word is registered in the result buffer, in its output register or, while
//  rsp stalls, in its skid register
//  a two-deep result buffer keeps req ready for one stalled rsp word
//  reset restores all link state to its initial values; the start-up delay comes back as 200 ticks
// ----------------------------------------------------------------------------
module keyboard_serial_link_decoder (
    input  logic       clk,
    input  logic       rst_n,
    kbd_req_if.sink    req,
    kbd_rsp_if.source  rsp,
    kbd_cfg_if.sink    cfg
);

    logic               req_ready;
    logic               req_take;
    kbd_link_pkg::rsp_t result;

    assign req.ready = req_ready;
    assign req_take  = req.valid && req_ready;
    assign cfg.ready = 1'b1;

    kbd_link_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_accept (req_take),
        .item        (req.data),
        .cfg_write   (cfg.valid),
        .cfg_data    (cfg.data),
        .result      (result)
    );

    kbd_link_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req_ready),
        .in_data   (result),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (rsp.data)
    );

endmodule
